// ===== design/ekf_measurement_update_core_defines.svh =====
// Assertion macros used by the top level of the update core.
`ifndef EKF_MEASUREMENT_UPDATE_CORE_DEFINES_SVH
`define EKF_MEASUREMENT_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EKFMU_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define EKFMU_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ekfmu_pkg.sv =====
// Shared types and codes of the measurement update core.
package ekfmu_pkg;

	typedef enum logic [3:0] {
		ACT_LD_X  = 4'd0,
		ACT_LD_P  = 4'd1,
		ACT_LD_Z  = 4'd2,
		ACT_LD_XP = 4'd3,
		ACT_LD_F  = 4'd4,
		ACT_LD_H  = 4'd5,
		ACT_LD_HJ = 4'd6,
		ACT_LD_Q  = 4'd7,
		ACT_LD_R  = 4'd8,
		ACT_RUN   = 4'd9,
		ACT_RD_P  = 4'd10,
		ACT_RD_X  = 4'd11
	} act_t;

	typedef enum logic [2:0] {
		K_MUL, K_ADD, K_SUB, K_IDSUB, K_IDENT, K_COPY, K_INV
	} op_kind_t;

	typedef enum logic [4:0] {
		P_FP, P_PP, P_PPQ, P_HP, P_S, P_SR, P_AL, P_AR, P_INV,
		P_PHT, P_K, P_V, P_KV, P_X, P_KH, P_IKH, P_PN, P_CP
	} step_t;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;

endpackage

// ===== design/ekfmu_div.sv =====
// Radix-2 restoring divider for fixed-point quotients with saturation.
module ekfmu_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ekfmu_pkg::div_req_t req,
	output ekfmu_pkg::div_rsp_t rsp
);
	import ekfmu_pkg::*;

	localparam int DW = 32 + FRAC_BITS;
	localparam int NW = $clog2(DW + 1);

	logic          busy_q, done_q, neg_q;
	logic [NW-1:0] cnt_q;
	logic [31:0]   rem_q, den_q;
	logic [DW-1:0] dvd_q;
	logic signed [31:0] quo_q;
	logic [32:0]   rsh;
	logic          fits;
	logic [31:0]   num_mag, den_mag;

	assign num_mag = req.num[31] ? (32'd0 - req.num) : req.num;
	assign den_mag = req.den[31] ? (32'd0 - req.den) : req.den;
	assign rsh     = {rem_q, dvd_q[DW-1]};
	assign fits    = rsh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(DW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			den_q <= den_mag;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fits ? 32'(rsh - {1'b0, den_q}) : rsh[31:0];
			dvd_q <= {dvd_q[DW-2:0], fits};
		end else if (busy_q) begin
			// dvd_q now holds the quotient magnitude
			if (!neg_q)
				quo_q <= (dvd_q > DW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : dvd_q[31:0];
			else
				quo_q <= (dvd_q > DW'(64'h8000_0000)) ? 32'sh8000_0000
					: 32'(32'd0 - dvd_q[31:0]);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== design/ekf_measurement_update_core.sv =====
// Top level of the extended Kalman filter measurement update core.
// Load transfers (one per cycle while idle) fill the state, covariance and update
// operands in one on-chip memory; a read transfer reads one element from memory and
// returns it through the output register, which out_stall can hold. A run transfer
// walks a fixed program of matrix steps through one shared 32x32 multiplier and
// accumulator: each product term passes a memory read, a multiply and a round and
// accumulate, and each element ends with a memory write. The Gauss-Jordan inversion
// waits in its row normalisation on a bit-serial divider for every element.
// The input side stalls for the whole run; the n state elements are then
// transferred in row order, the final one flagged with last. A zero pivot sets
// status and leaves state and covariance untouched. Never-written entries read
// as whatever the memory holds.
`include "ekf_measurement_update_core_defines.svh"

module ekf_measurement_update_core #(
	parameter int STATE_DIM = 4,
	parameter int MEAS_DIM  = 2,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         action,
	input  logic [2:0]         row,
	input  logic [2:0]         col,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value_res,
	output logic [2:0]         row_res,
	output logic [2:0]         col_res,
	output logic               status,
	output logic               last
);
	import ekfmu_pkg::*;

	localparam int N  = STATE_DIM;
	localparam int M  = MEAS_DIM;
	localparam int NN = N * N;
	localparam int MN = M * N;
	localparam int MM = M * M;

	// memory map: every matrix lives row-major in one array
	localparam int B_X   = 0;
	localparam int B_P   = B_X + N;
	localparam int B_Z   = B_P + NN;
	localparam int B_XP  = B_Z + M;
	localparam int B_F   = B_XP + N;
	localparam int B_HV  = B_F + NN;
	localparam int B_HJ  = B_HV + M;
	localparam int B_Q   = B_HJ + MN;
	localparam int B_R   = B_Q + NN;
	localparam int B_FP  = B_R + MM;
	localparam int B_PP  = B_FP + NN;
	localparam int B_HP  = B_PP + NN;
	localparam int B_S   = B_HP + MN;
	localparam int B_AL  = B_S + MM;   // left half of [S | I]
	localparam int B_AR  = B_AL + MM;  // right half, ends as inverse of S
	localparam int B_PHT = B_AR + MM;
	localparam int B_K   = B_PHT + MN;
	localparam int B_V   = B_K + MN;
	localparam int B_KV  = B_V + M;
	localparam int B_KH  = B_KV + N;
	localparam int B_PN  = B_KH + NN;
	localparam int DEPTH = B_PN + NN;
	localparam int AW    = $clog2(DEPTH);

	localparam int MAXD  = (N > 2 * M) ? N : 2 * M;
	localparam int CW    = $clog2(MAXD + 1);
	localparam int ACC_W = 64 - FRAC_BITS + 4;
	localparam logic signed [ACC_W-1:0] ONE_Q = ACC_W'(64'd1 << FRAC_BITS);

	typedef enum logic [28:0] {
		ST_IDLE     = 29'h1 << 0,
		ST_OPSTART  = 29'h1 << 1,
		ST_RD       = 29'h1 << 2,
		ST_MUL      = 29'h1 << 3,
		ST_ACC      = 29'h1 << 4,
		ST_WR       = 29'h1 << 5,
		ST_NEXT     = 29'h1 << 6,
		ST_IV_COL   = 29'h1 << 7,
		ST_IV_SCRD  = 29'h1 << 8,
		ST_IV_SCCMP = 29'h1 << 9,
		ST_IV_SCEND = 29'h1 << 10,
		ST_IV_SWRD  = 29'h1 << 11,
		ST_IV_SWW1  = 29'h1 << 12,
		ST_IV_SWW2  = 29'h1 << 13,
		ST_IV_PVRD  = 29'h1 << 14,
		ST_IV_PVCAP = 29'h1 << 15,
		ST_IV_DVRD  = 29'h1 << 16,
		ST_IV_DVGO  = 29'h1 << 17,
		ST_IV_DVWT  = 29'h1 << 18,
		ST_IV_ELROW = 29'h1 << 19,
		ST_IV_FRD   = 29'h1 << 20,
		ST_IV_FCAP  = 29'h1 << 21,
		ST_IV_ELRD  = 29'h1 << 22,
		ST_IV_ELMUL = 29'h1 << 23,
		ST_IV_ELWR  = 29'h1 << 24,
		ST_EMRD     = 29'h1 << 25,
		ST_EMOUT    = 29'h1 << 26,
		ST_RQRD     = 29'h1 << 27,
		ST_RQOUT    = 29'h1 << 28
	} state_t;

	typedef struct packed {
		op_kind_t      kind;
		logic [AW-1:0] a;
		logic [AW-1:0] b;
		logic [AW-1:0] c;
		logic [CW-1:0] rows;
		logic [CW-1:0] inner;
		logic [CW-1:0] cols;
		logic          bt;
	} desc_t;

	state_t         state_q;
	step_t          pc_q;
	desc_t          desc;
	logic [CW-1:0]  i_q, j_q, k_q, ic_q, ip_q;
	logic [32:0]    best_q, mag;
	logic signed [31:0] piv_q, f_q, rda_q, rdb_q;
	logic signed [63:0] prod_q;
	logic signed [ACC_W-1:0] acc_q, term, ea, eb, idv, el_val;
	logic           last_status_q;

	logic [31:0]    mem_q [DEPTH];
	logic           mem_we, rd_en;
	logic [AW-1:0]  mem_waddr, addr_a, addr_b;
	logic signed [31:0] mem_wdata, mul_a;
	logic [AW-1:0]  op_a, op_b, op_c;

	logic           in_acc, out_free, ld_ok, rq_ok;
	logic [AW-1:0]  ld_addr, rq_addr;
	logic [AW-1:0]  rq_addr_q;
	logic           rq_ok_q;
	logic [2:0]     rq_row_q, rq_col_q;

	logic           out_valid_q, out_load;
	logic signed [31:0] out_value_q, out_load_value;
	logic [2:0]     out_row_q, out_col_q, out_load_row, out_load_col;
	logic           out_status_q, out_last_q, out_load_last;

	div_req_t       div_req;
	div_rsp_t       div_rsp;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]))
			return v[31:0];
		else if (v[ACC_W-1])
			return 32'sh8000_0000;
		else
			return 32'sh7FFF_FFFF;
	endfunction

	// round to nearest, ties upward, back to FRAC_BITS fraction bits
	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [63:0] p);
		logic signed [63:0] t;
		logic signed [63-FRAC_BITS:0] s;
		t = p + (64'sd1 <<< (FRAC_BITS - 1));
		s = t[63:FRAC_BITS];
		return ACC_W'(s);
	endfunction

	function automatic logic [AW-1:0] aug_addr(input logic [CW-1:0] r,
		input logic [CW-1:0] c);
		int ri, ci;
		ri = int'(r);
		ci = int'(c);
		if (ci < M)
			return AW'(B_AL + ri * M + ci);
		else
			return AW'(B_AR + ri * M + ci - M);
	endfunction

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------- program
	always_comb begin
		desc = '0;
		desc.kind = K_MUL;
		unique case (pc_q)
			P_FP:  desc = '{K_MUL, AW'(B_F), AW'(B_P), AW'(B_FP),
				CW'(N), CW'(N), CW'(N), 1'b0};
			P_PP:  desc = '{K_MUL, AW'(B_FP), AW'(B_F), AW'(B_PP),
				CW'(N), CW'(N), CW'(N), 1'b1};
			P_PPQ: desc = '{K_ADD, AW'(B_PP), AW'(B_Q), AW'(B_PP),
				CW'(N), CW'(1), CW'(N), 1'b0};
			P_HP:  desc = '{K_MUL, AW'(B_HJ), AW'(B_PP), AW'(B_HP),
				CW'(M), CW'(N), CW'(N), 1'b0};
			P_S:   desc = '{K_MUL, AW'(B_HP), AW'(B_HJ), AW'(B_S),
				CW'(M), CW'(N), CW'(M), 1'b1};
			P_SR:  desc = '{K_ADD, AW'(B_S), AW'(B_R), AW'(B_S),
				CW'(M), CW'(1), CW'(M), 1'b0};
			P_AL:  desc = '{K_COPY, AW'(B_S), AW'(B_S), AW'(B_AL),
				CW'(M), CW'(1), CW'(M), 1'b0};
			P_AR:  desc = '{K_IDENT, AW'(B_S), AW'(B_S), AW'(B_AR),
				CW'(M), CW'(1), CW'(M), 1'b0};
			P_INV: desc = '{K_INV, AW'(B_AL), AW'(B_AL), AW'(B_AL),
				CW'(M), CW'(1), CW'(M), 1'b0};
			P_PHT: desc = '{K_MUL, AW'(B_PP), AW'(B_HJ), AW'(B_PHT),
				CW'(N), CW'(N), CW'(M), 1'b1};
			P_K:   desc = '{K_MUL, AW'(B_PHT), AW'(B_AR), AW'(B_K),
				CW'(N), CW'(M), CW'(M), 1'b0};
			P_V:   desc = '{K_SUB, AW'(B_Z), AW'(B_HV), AW'(B_V),
				CW'(M), CW'(1), CW'(1), 1'b0};
			P_KV:  desc = '{K_MUL, AW'(B_K), AW'(B_V), AW'(B_KV),
				CW'(N), CW'(M), CW'(1), 1'b0};
			P_X:   desc = '{K_ADD, AW'(B_XP), AW'(B_KV), AW'(B_X),
				CW'(N), CW'(1), CW'(1), 1'b0};
			P_KH:  desc = '{K_MUL, AW'(B_K), AW'(B_HJ), AW'(B_KH),
				CW'(N), CW'(M), CW'(N), 1'b0};
			P_IKH: desc = '{K_IDSUB, AW'(B_KH), AW'(B_KH), AW'(B_KH),
				CW'(N), CW'(1), CW'(N), 1'b0};
			P_PN:  desc = '{K_MUL, AW'(B_KH), AW'(B_PP), AW'(B_PN),
				CW'(N), CW'(N), CW'(N), 1'b0};
			P_CP:  desc = '{K_COPY, AW'(B_PN), AW'(B_PN), AW'(B_P),
				CW'(N), CW'(1), CW'(N), 1'b0};
			default: desc.kind = K_MUL;
		endcase
	end

	// element addresses of the current step
	always_comb begin
		if (desc.kind == K_MUL) begin
			op_a = AW'(int'(desc.a) + int'(i_q) * int'(desc.inner) + int'(k_q));
			if (desc.bt)
				op_b = AW'(int'(desc.b) + int'(j_q) * int'(desc.inner) + int'(k_q));
			else
				op_b = AW'(int'(desc.b) + int'(k_q) * int'(desc.cols) + int'(j_q));
		end else begin
			op_a = AW'(int'(desc.a) + int'(i_q) * int'(desc.cols) + int'(j_q));
			op_b = AW'(int'(desc.b) + int'(i_q) * int'(desc.cols) + int'(j_q));
		end
		op_c = AW'(int'(desc.c) + int'(i_q) * int'(desc.cols) + int'(j_q));
	end

	// ---------------------------------------------------------------- datapath
	always_comb begin
		ea  = rda_q;
		eb  = rdb_q;
		idv = (i_q == j_q) ? ONE_Q : '0;
		case (desc.kind)
			K_MUL:   term = rnd(prod_q);
			K_ADD:   term = ea + eb;
			K_SUB:   term = ea - eb;
			K_IDSUB: term = idv - ea;
			K_IDENT: term = idv;
			K_COPY:  term = ea;
			default: term = '0;
		endcase
		el_val = ea - rnd(prod_q);
		mag    = rda_q[31] ? (33'd0 - {1'b1, rda_q}) : {1'b0, rda_q};
		mul_a  = (state_q == ST_IV_ELMUL) ? f_q : rda_q;
	end

	// load and read decode
	always_comb begin
		ld_ok   = 1'b0;
		ld_addr = '0;
		unique case (action)
			ACT_LD_X: begin
				ld_ok   = int'(row) < N;
				ld_addr = AW'(B_X + int'(row));
			end
			ACT_LD_P: begin
				ld_ok   = int'(row) < N && int'(col) < N;
				ld_addr = AW'(B_P + int'(row) * N + int'(col));
			end
			ACT_LD_Z: begin
				ld_ok   = int'(row) < M;
				ld_addr = AW'(B_Z + int'(row));
			end
			ACT_LD_XP: begin
				ld_ok   = int'(row) < N;
				ld_addr = AW'(B_XP + int'(row));
			end
			ACT_LD_F: begin
				ld_ok   = int'(row) < N && int'(col) < N;
				ld_addr = AW'(B_F + int'(row) * N + int'(col));
			end
			ACT_LD_H: begin
				ld_ok   = int'(row) < M;
				ld_addr = AW'(B_HV + int'(row));
			end
			ACT_LD_HJ: begin
				ld_ok   = int'(row) < M && int'(col) < N;
				ld_addr = AW'(B_HJ + int'(row) * N + int'(col));
			end
			ACT_LD_Q: begin
				ld_ok   = int'(row) < N && int'(col) < N;
				ld_addr = AW'(B_Q + int'(row) * N + int'(col));
			end
			ACT_LD_R: begin
				ld_ok   = int'(row) < M && int'(col) < M;
				ld_addr = AW'(B_R + int'(row) * M + int'(col));
			end
			default: ld_ok = 1'b0;
		endcase
		if (action == ACT_RD_P) begin
			rq_ok   = int'(row) < N && int'(col) < N;
			rq_addr = rq_ok ? AW'(B_P + int'(row) * N + int'(col)) : '0;
		end else begin
			rq_ok   = int'(row) < N;
			rq_addr = rq_ok ? AW'(B_X + int'(row)) : '0;
		end
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		rd_en     = 1'b0;
		addr_a    = '0;
		addr_b    = '0;
		div_req   = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_we    = in_acc && ld_ok;
				mem_waddr = ld_addr;
				mem_wdata = value;
			end
			ST_RD: begin
				rd_en  = 1'b1;
				addr_a = op_a;
				addr_b = op_b;
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_waddr = op_c;
				mem_wdata = sat32(acc_q);
			end
			ST_IV_SCRD, ST_IV_FRD: begin
				rd_en  = 1'b1;
				addr_a = aug_addr(i_q, ic_q);
			end
			ST_IV_SWRD: begin
				rd_en  = 1'b1;
				addr_a = aug_addr(ic_q, j_q);
				addr_b = aug_addr(ip_q, j_q);
			end
			ST_IV_SWW1: begin
				mem_we    = 1'b1;
				mem_waddr = aug_addr(ic_q, j_q);
				mem_wdata = rdb_q;
			end
			ST_IV_SWW2: begin
				mem_we    = 1'b1;
				mem_waddr = aug_addr(ip_q, j_q);
				mem_wdata = rda_q;
			end
			ST_IV_PVRD: begin
				rd_en  = 1'b1;
				addr_a = aug_addr(ic_q, ic_q);
			end
			ST_IV_DVRD: begin
				rd_en  = 1'b1;
				addr_a = aug_addr(ic_q, j_q);
			end
			ST_IV_DVGO: begin
				div_req.start = 1'b1;
				div_req.num   = rda_q;
				div_req.den   = piv_q;
			end
			ST_IV_DVWT: begin
				mem_we    = div_rsp.done;
				mem_waddr = aug_addr(ic_q, j_q);
				mem_wdata = div_rsp.quo;
			end
			ST_IV_ELRD: begin
				rd_en  = 1'b1;
				addr_a = aug_addr(i_q, j_q);
				addr_b = aug_addr(ic_q, j_q);
			end
			ST_IV_ELWR: begin
				mem_we    = 1'b1;
				mem_waddr = aug_addr(i_q, j_q);
				mem_wdata = sat32(el_val);
			end
			ST_EMRD: begin
				rd_en  = 1'b1;
				addr_a = AW'(B_X + int'(i_q));
			end
			ST_RQRD: begin
				rd_en  = 1'b1;
				addr_a = rq_addr_q;
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		if (rd_en) begin
			rda_q <= mem_q[addr_a];
			rdb_q <= mem_q[addr_b];
		end
	end

	ekfmu_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pc_q          <= P_FP;
			i_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			ic_q          <= '0;
			ip_q          <= '0;
			last_status_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (action == ACT_RUN) begin
							pc_q    <= P_FP;
							state_q <= ST_OPSTART;
						end else if (action == ACT_RD_P || action == ACT_RD_X) begin
							state_q <= ST_RQRD;
						end
					end
				end
				ST_OPSTART: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
					if (desc.kind == K_INV) begin
						ic_q    <= '0;
						state_q <= ST_IV_COL;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (desc.kind == K_MUL && int'(k_q) + 1 < int'(desc.inner)) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					k_q <= '0;
					if (int'(j_q) + 1 < int'(desc.cols)) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_RD;
					end else begin
						j_q <= '0;
						if (int'(i_q) + 1 < int'(desc.rows)) begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					if (pc_q == P_CP) begin
						last_status_q <= 1'b0;
						i_q           <= '0;
						state_q       <= ST_EMRD;
					end else begin
						pc_q    <= step_t'(pc_q + 5'd1);
						state_q <= ST_OPSTART;
					end
				end
				// pivot search down column ic
				ST_IV_COL: begin
					i_q     <= ic_q;
					ip_q    <= ic_q;
					state_q <= ST_IV_SCRD;
				end
				ST_IV_SCRD: state_q <= ST_IV_SCCMP;
				ST_IV_SCCMP: begin
					if (mag > best_q)
						ip_q <= i_q;
					if (int'(i_q) + 1 < M) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_IV_SCRD;
					end else begin
						state_q <= ST_IV_SCEND;
					end
				end
				ST_IV_SCEND: begin
					j_q <= '0;
					if (best_q == '0) begin
						last_status_q <= 1'b1;
						i_q           <= '0;
						state_q       <= ST_EMRD;
					end else if (ip_q != ic_q) begin
						state_q <= ST_IV_SWRD;
					end else begin
						state_q <= ST_IV_PVRD;
					end
				end
				ST_IV_SWRD: state_q <= ST_IV_SWW1;
				ST_IV_SWW1: state_q <= ST_IV_SWW2;
				ST_IV_SWW2: begin
					if (int'(j_q) + 1 < 2 * M) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_IV_SWRD;
					end else begin
						state_q <= ST_IV_PVRD;
					end
				end
				ST_IV_PVRD:  state_q <= ST_IV_PVCAP;
				ST_IV_PVCAP: begin
					j_q     <= '0;
					state_q <= ST_IV_DVRD;
				end
				ST_IV_DVRD: state_q <= ST_IV_DVGO;
				ST_IV_DVGO: state_q <= ST_IV_DVWT;
				ST_IV_DVWT: begin
					if (div_rsp.done) begin
						if (int'(j_q) + 1 < 2 * M) begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_IV_DVRD;
						end else begin
							i_q     <= '0;
							state_q <= ST_IV_ELROW;
						end
					end
				end
				ST_IV_ELROW: begin
					if (int'(i_q) >= M) begin
						if (int'(ic_q) + 1 < M) begin
							ic_q    <= ic_q + 1'b1;
							state_q <= ST_IV_COL;
						end else begin
							state_q <= ST_NEXT;
						end
					end else if (i_q == ic_q) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= ST_IV_FRD;
					end
				end
				ST_IV_FRD:  state_q <= ST_IV_FCAP;
				ST_IV_FCAP: begin
					j_q     <= '0;
					state_q <= ST_IV_ELRD;
				end
				ST_IV_ELRD:  state_q <= ST_IV_ELMUL;
				ST_IV_ELMUL: state_q <= ST_IV_ELWR;
				ST_IV_ELWR: begin
					if (int'(j_q) + 1 < 2 * M) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_IV_ELRD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_IV_ELROW;
					end
				end
				ST_EMRD: state_q <= ST_EMOUT;
				ST_EMOUT: begin
					if (out_free) begin
						if (int'(i_q) == N - 1) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_EMRD;
						end
					end
				end
				ST_RQRD: state_q <= ST_RQOUT;
				ST_RQOUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers of the shared unit
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL || state_q == ST_IV_ELMUL)
			prod_q <= mul_a * rdb_q;
		if (state_q == ST_OPSTART || state_q == ST_WR)
			acc_q <= '0;
		else if (state_q == ST_ACC)
			acc_q <= acc_q + term;
		if (state_q == ST_IV_COL)
			best_q <= '0;
		else if (state_q == ST_IV_SCCMP && mag > best_q)
			best_q <= mag;
		if (state_q == ST_IV_PVCAP)
			piv_q <= rda_q;
		if (state_q == ST_IV_FCAP)
			f_q <= rda_q;
		if (state_q == ST_IDLE && in_acc) begin
			rq_addr_q <= rq_addr;
			rq_ok_q   <= rq_ok;
			rq_row_q  <= row;
			rq_col_q  <= (action == ACT_RD_P) ? col : 3'd0;
		end
	end

	// ---------------------------------------------------------------- output register
	always_comb begin
		out_load       = 1'b0;
		out_load_value = rda_q;
		out_load_row   = 3'(i_q);
		out_load_col   = 3'd0;
		out_load_last  = (int'(i_q) == N - 1);
		if (state_q == ST_EMOUT) begin
			out_load = out_free;
		end else if (state_q == ST_RQOUT) begin
			out_load       = out_free;
			out_load_value = rq_ok_q ? rda_q : 32'sd0;
			out_load_row   = rq_row_q;
			out_load_col   = rq_col_q;
			out_load_last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= out_load_value;
			out_row_q    <= out_load_row;
			out_col_q    <= out_load_col;
			out_status_q <= last_status_q;
			out_last_q   <= out_load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = out_value_q;
	assign row_res   = out_row_q;
	assign col_res   = out_col_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

	// ---------------------------------------------------------------- assertions
	`EKFMU_AST_IMP(a_piv_nonzero, state_q == ST_IV_DVWT, piv_q != 32'sd0, "division by zero pivot")
	`EKFMU_AST_NXT(a_run_last, state_q == ST_EMOUT && out_free && int'(i_q) == N - 1, out_valid && last, "final state transfer not flagged")
	`EKFMU_AST_IMP(a_waddr_range, mem_we, int'(mem_waddr) < DEPTH, "memory write beyond map")

endmodule
